// File: sv/knuth_yao_gaussian_sampler_assert.svh
// Assertion macros for the Knuth-Yao sampler checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef KNUTH_YAO_GAUSSIAN_SAMPLER_ASSERT_SVH
`define KNUTH_YAO_GAUSSIAN_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KYGS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kygs assertion failed");

// Next-cycle implication, disabled during reset.
`define KYGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kygs assertion failed");

`endif

// File: sv/kygs_pkg.sv
// Shared constants and types for the Knuth-Yao discrete Gaussian sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package kygs_pkg;

   localparam int ROWS        = 22;
   localparam int COLS        = 32;
   localparam int WORD_BITS   = 32;
   localparam int IDX_W       = 5;
   localparam int ROW_AW      = $clog2(ROWS);
   localparam int COL_W       = $clog2(COLS + 1);
   localparam int WB_W        = $clog2(WORD_BITS);
   localparam int DIST_W      = 7;
   localparam int DIST_MAX    = (2 ** DIST_W) - 1;
   localparam int SAMPLE_W    = 6;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BIT  = 1'b1;

   typedef struct packed {
      logic                 wr_en;
      logic [ROW_AW-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ROW_AW-1:0]    rd_addr;
   } store_req_type;

endpackage

`default_nettype wire

// File: sv/kygs_row_store.sv
// Probability row memory with a registered read port and column bit select.
// Depends on kygs_pkg.
`default_nettype none

module kygs_row_store
   import kygs_pkg::*;
(
   input  wire logic          clock,
   input  wire store_req_type store_req,
   input  wire logic [COL_W-1:0] column,
   output logic               row_bit
);

   logic [WORD_BITS-1:0] rows_mem [ROWS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WB_W-1:0]      bit_pos;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         rows_mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= rows_mem[store_req.rd_addr];
      end
   end

   // Column zero is the MSB of the row word; columns past the word read zero.
   assign bit_pos = WB_W'(WORD_BITS - 1) - column[WB_W-1:0];
   assign row_bit = (int'(column) < WORD_BITS) ? rd_data_ff[bit_pos] : 1'b0;

endmodule

`default_nettype wire

// File: sv/knuth_yao_gaussian_sampler.sv
// Knuth-Yao discrete Gaussian sampler: top level with the walk sequencer.
// Depends on kygs_pkg and kygs_row_store.
//
// Usage: a request with tuser = 0 loads one probability row (row_index,
// row_word); loads to rows at or past the table size are dropped. A request
// with tuser = 1 supplies one random bit. During the walk each bit doubles
// the distance, adds the bit, and starts a scan over the rows from the last
// to the first, one row per cycle through the single subtract-and-compare
// unit and the registered memory read port. The bit after the walk ends is
// the sign and yields one response, sample, in the next cycle.
// A load or a sign bit needs no scan; a walk bit is followed by a scan that
// stops early on a hit, else after the first row.
// req_tready is low while a scan runs, and also while a response is stalled
// and a finished walk waits for its sign bit (loads wait as well). The
// response sits in an output register until taken; once the sign is taken,
// loads and walk bits are accepted meanwhile.
// Reset clears the walk state and the response valid; the table keeps its
// contents and must be loaded before sampling.
`default_nettype none

module knuth_yao_gaussian_sampler
   import kygs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // row_index [4:0], row_word [36:5], random_bit [37], zero [39:38]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind [0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // sample [5:0], zero [7:6]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                 state_ff, state_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [COL_W-1:0]     column_ff, column_in;
   logic                 awaiting_ff, awaiting_in;
   logic [ROW_AW-1:0]    chosen_ff, chosen_in;
   logic [ROW_AW-1:0]    row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;

   logic [IDX_W-1:0]     row_index;
   logic [WORD_BITS-1:0] row_word;
   logic                 random_bit;
   logic                 req_accept;
   logic [DIST_W:0]      dist_doubled;
   logic [SAMPLE_W-1:0]  mag_ext;
   logic [COL_W:0]       column_next;
   logic                 row_bit;
   logic                 hit;
   store_req_type        store_req;

   assign row_index  = req_tdata[IDX_W-1:0];
   assign row_word   = req_tdata[IDX_W+WORD_BITS-1:IDX_W];
   assign random_bit = req_tdata[IDX_W+WORD_BITS];

   assign req_tready = (state_ff == ST_IDLE) && (!awaiting_ff || !rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign dist_doubled = {dist_ff, random_bit};
   assign mag_ext      = SAMPLE_W'(chosen_ff);
   assign column_next  = {1'b0, column_ff} + 1'b1;
   assign hit          = row_bit && (dist_ff == '0);

   kygs_row_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .column    (column_ff),
      .row_bit   (row_bit)
   );

   always_comb begin
      state_in     = state_ff;
      dist_in      = dist_ff;
      column_in    = column_ff;
      awaiting_in  = awaiting_ff;
      chosen_in    = chosen_ff;
      row_in       = row_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = ROW_AW'(row_index);
      store_req.wr_data = row_word;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = ROW_AW'(ROWS - 1);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == KIND_LOAD) begin
                  store_req.wr_en = (int'(row_index) < ROWS);
               end else if (awaiting_ff) begin
                  sample_in    = random_bit ? mag_ext : (SAMPLE_W'(0) - mag_ext);
                  rsp_valid_in = 1'b1;
                  dist_in      = '0;
                  column_in    = '0;
                  awaiting_in  = 1'b0;
                  chosen_in    = '0;
               end else begin
                  // Double and add the bit, saturating; fetch the last row.
                  dist_in         = (int'(dist_doubled) > DIST_MAX) ?
                                    DIST_W'(DIST_MAX) : dist_doubled[DIST_W-1:0];
                  store_req.rd_en = 1'b1;
                  row_in          = ROW_AW'(ROWS - 1);
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               chosen_in   = row_ff;
               dist_in     = '0;
               awaiting_in = 1'b1;
               column_in   = column_next[COL_W-1:0];
               state_in    = ST_IDLE;
            end else begin
               dist_in = dist_ff - DIST_W'(row_bit);
               if (row_ff == '0) begin
                  column_in = column_next[COL_W-1:0];
                  state_in  = ST_IDLE;
                  // All columns spent without a hit: magnitude zero.
                  if (int'(column_next) >= COLS) begin
                     chosen_in   = '0;
                     dist_in     = '0;
                     awaiting_in = 1'b1;
                  end
               end else begin
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = row_ff - 1'b1;
                  row_in            = row_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dist_ff      <= '0;
         column_ff    <= '0;
         awaiting_ff  <= 1'b0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dist_ff      <= dist_in;
         column_ff    <= column_in;
         awaiting_ff  <= awaiting_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      sample_ff <= sample_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(sample_ff);

endmodule

`default_nettype wire

// File: sv/kygs_checker.sv
// Port-level assertions for the Knuth-Yao sampler, bound to the top level.
// Depends on kygs_pkg and knuth_yao_gaussian_sampler_assert.svh.
`default_nettype none

`include "knuth_yao_gaussian_sampler_assert.svh"

module kygs_checker
   import kygs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic signed [SAMPLE_W-1:0] sample;
   logic                       bit_accept;
   logic                       load_accept;

   assign sample      = $signed(rsp_tdata[SAMPLE_W-1:0]);
   assign bit_accept  = req_tvalid && req_tready && (req_tuser == KIND_BIT);
   assign load_accept = req_tvalid && req_tready && (req_tuser == KIND_LOAD);

   `KYGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))
   `KYGS_ASSERT_SAME(a_sample_range, clock, reset, rsp_tvalid,
                     (int'(sample) <= ROWS - 1) && (int'(sample) >= 1 - ROWS))
   `KYGS_ASSERT_SAME(a_rsp_from_bit, clock, reset, $rose(rsp_tvalid), $past(bit_accept))
   `KYGS_ASSERT_NEXT(a_load_silent, clock, reset, load_accept, !$rose(rsp_tvalid))

endmodule

bind knuth_yao_gaussian_sampler kygs_checker u_kygs_checker (.*);

`default_nettype wire

// File: test/kygs_sample_checker.sv
// Sample checker for the Knuth-Yao sampler: mirrors the probability table and the
// walk from accepted requests and compares each response with the predicted sample.
// Depends on kygs_pkg.
`timescale 1ns / 100ps

module kygs_sample_checker
   import kygs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // row_index [4:0], row_word [36:5], random_bit [37], zero [39:38]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind [0]
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // sample [5:0], zero [7:6]
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          error_count,
   output int                          samples_due
);

   logic [WORD_BITS-1:0]   prob_table [ROWS];
   logic [DIST_W-1:0]      walk_dist;
   logic [COL_W-1:0]       walk_col;
   logic                   sign_next;
   logic [IDX_W-1:0]       walk_mag;
   logic [RSP_TDATA_W-1:0] expected_samples [$];
   logic [RSP_TDATA_W-1:0] want_sample;
   int                     mismatches = 0;

   function automatic logic table_bit(int row, logic [COL_W-1:0] col);
      // columns past the row word read as zero
      if (col >= WORD_BITS) return 1'b0;
      return prob_table[row][WORD_BITS-1-col];
   endfunction

   task automatic take_request(input logic kind, input logic [REQ_TDATA_W-1:0] data);
      logic [IDX_W-1:0]    idx;
      logic                rbit;
      logic [SAMPLE_W-1:0] mag6;
      logic [SAMPLE_W-1:0] sval;
      int                  d;
      int                  r;
      logic                hit;
      idx  = data[IDX_W-1:0];
      rbit = data[IDX_W+WORD_BITS];
      if (kind == KIND_LOAD) begin
         // drop loads past the table
         if (idx < ROWS) prob_table[idx] = data[IDX_W +: WORD_BITS];
      end else if (sign_next) begin
         mag6 = SAMPLE_W'(walk_mag);
         sval = rbit ? mag6 : -mag6;
         expected_samples.push_back({{(RSP_TDATA_W-SAMPLE_W){1'b0}}, sval});
         walk_dist = '0;
         walk_col  = '0;
         walk_mag  = '0;
         sign_next = 1'b0;
      end else begin
         d = 2 * walk_dist + rbit;
         if (d > DIST_MAX) d = DIST_MAX;
         hit = 1'b0;
         r = ROWS - 1;
         while (!hit && r >= 0) begin
            if (table_bit(r, walk_col)) d = d - 1;
            if (d == -1) begin
               walk_mag = r[IDX_W-1:0];
               hit = 1'b1;
            end else begin
               r = r - 1;
            end
         end
         walk_col = walk_col + 1'b1;
         if (hit) begin
            walk_dist = '0;
            sign_next = 1'b1;
         end else begin
            walk_dist = d[DIST_W-1:0];
            // out of columns: magnitude zero
            if (walk_col >= COLS) begin
               walk_mag  = '0;
               walk_dist = '0;
               sign_next = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walk_dist = '0;
         walk_col  = '0;
         walk_mag  = '0;
         sign_next = 1'b0;
         expected_samples.delete();
      end else begin
         // check before taking the request: a sign accepted now answers next cycle
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual sample %0d (tdata %h)",
                        $time, $signed(rsp_tdata[SAMPLE_W-1:0]), rsp_tdata);
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_tdata !== want_sample) begin
                  mismatches++;
                  $display("%0t: sample mismatch, expected %0d (tdata %h), actual %0d (tdata %h)",
                           $time, $signed(want_sample[SAMPLE_W-1:0]), want_sample,
                           $signed(rsp_tdata[SAMPLE_W-1:0]), rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
      end
      error_count <= mismatches;
      samples_due <= expected_samples.size();
   end

endmodule

// File: test/testbench.sv
// Top of the Knuth-Yao sampler testbench: clock, reset, request and response
// stimulus with random gaps, and the verdict. Depends on kygs_pkg, the sampler
// and kygs_sample_checker.
`timescale 1ns / 100ps

module testbench;
   import kygs_pkg::*;

   localparam int ITEM_TARGET = 1800;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum {TBL_DENSE, TBL_TAPERED, TBL_SPARSE, TBL_EMPTY, TBL_SINGLE} table_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     error_count;
   int                     samples_due;
   int                     items_sent = 0;
   int                     cycle_count = 0;
   int                     ready_left = 0;
   bit                     steady = 1'b0;
   int                     lone_row = 0;
   int                     lone_col = 0;

   knuth_yao_gaussian_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   kygs_sample_checker sample_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .samples_due (samples_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side: runs of ready alternate with stalls
   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else if (steady || $urandom_range(0, 2) != 0) begin
         rsp_tready <= 1'b1;
         ready_left <= $urandom_range(0, 30);
      end else begin
         rsp_tready <= 1'b0;
         ready_left <= pick_gap();
      end
   end

   function automatic logic [WORD_BITS-1:0] row_pattern(table_style_type style, int row);
      case (style)
         TBL_DENSE:   return $urandom;
         TBL_TAPERED: return $urandom >> row;
         TBL_SPARSE:  return $urandom & $urandom & $urandom & $urandom;
         TBL_SINGLE:  return (row == lone_row) ? (WORD_BITS'(1) << lone_col) : '0;
         default:     return '0;
      endcase
   endfunction

   // hold valid high across back-to-back requests, drop it only for a gap
   task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [WORD_BITS-1:0] word, input logic rbit);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W-IDX_W-WORD_BITS-1){1'b0}}, rbit, word, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_bit(input logic rbit);
      send_req(KIND_BIT, IDX_W'($urandom), $urandom, rbit);
   endtask

   initial begin : stimulus
      table_style_type style;
      int              roll;
      int              row;
      int              walk_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // hit in the last column: only row 5, column 31 set, all-zero walk bits
      for (int r = 0; r < ROWS; r++) begin
         send_req(KIND_LOAD, IDX_W'(r), (r == 5) ? 32'h1 : '0, 1'b0);
      end
      repeat (COLS) send_bit(1'b0);
      send_bit(1'b1);
      // hit on the top row in the first column, negative sign
      send_req(KIND_LOAD, IDX_W'(5), '0, 1'b1);
      send_req(KIND_LOAD, IDX_W'(ROWS - 1), 32'h8000_0000, 1'b0);
      send_bit(1'b0);
      send_bit(1'b0);
      // empty table: distance saturates, no hit, magnitude zero
      send_req(KIND_LOAD, IDX_W'(ROWS - 1), '0, 1'b1);
      repeat (COLS) send_bit(1'b1);
      send_bit(1'b0);
      // loads past the table are dropped
      send_req(KIND_LOAD, IDX_W'(ROWS), '1, 1'b1);
      send_req(KIND_LOAD, '1, '1, 1'b0);
      send_req(KIND_LOAD, '0, '1, 1'b1);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);
      send_req(KIND_LOAD, IDX_W'(ROWS - 1), '1, 1'b0);
      send_bit(1'b1);
      send_bit(1'b0);

      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)      style = TBL_DENSE;
         else if (roll < 60) style = TBL_TAPERED;
         else if (roll < 80) style = TBL_SPARSE;
         else if (roll < 88) style = TBL_EMPTY;
         else                style = TBL_SINGLE;
         lone_row = $urandom_range(0, ROWS - 1);
         lone_col = $urandom_range(0, WORD_BITS - 1);
         steady   = ($urandom_range(0, 5) == 0);
         for (int r = 0; r < ROWS; r++) begin
            send_req(KIND_LOAD, IDX_W'(r), row_pattern(style, r), 1'($urandom));
         end
         walk_len = $urandom_range(30, 80);
         repeat (walk_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               // rewrite a row in the middle of a walk
               row = $urandom_range(0, ROWS - 1);
               send_req(KIND_LOAD, IDX_W'(row), row_pattern(style, row), 1'($urandom));
            end else if (roll < 9) begin
               send_req(KIND_LOAD, IDX_W'($urandom_range(ROWS, (1 << IDX_W) - 1)),
                        $urandom, 1'($urandom));
            end else begin
               send_bit(1'($urandom));
            end
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (samples_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && samples_due == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/kygs_pkg.sv
sv/kygs_row_store.sv
sv/knuth_yao_gaussian_sampler.sv
sv/kygs_checker.sv
test/kygs_sample_checker.sv
test/testbench.sv
